// ----- sv/tdp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tdp_pkg: shared types for the trial division prime test
// sequencer states and the status word from the remainder unit
// ----------------------------------------------------------------------------
package tdp_pkg;

    // sequencer states of the top level
    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_DONE
    } tdp_state_t;

    // status from the remainder unit to the sequencer
    typedef struct packed {
        logic done;
        logic rem_zero;
    } tdp_rem_sts_t;

endpackage
`default_nettype wire

// ----- sv/tdp_rem_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tdp_rem_unit: bit-serial remainder unit
// restoring division, one dividend bit per cycle; the divisor must stay
// stable from start until done
// ----------------------------------------------------------------------------
module tdp_rem_unit
    import tdp_pkg::*;
#(
    parameter int NUM_W = 16,
    parameter int DIV_W = 9
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] dividend,
    input  wire logic [DIV_W-1:0] divisor,
    output tdp_rem_sts_t          sts
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg,  busy_next;
    logic             done_reg,  done_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic [NUM_W-1:0] shift_reg, shift_next;
    logic [DIV_W-1:0] rem_reg,   rem_next;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;

    // one restoring step: bring in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, shift_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        if (start) begin
            busy_next  = 1'b1;
            cnt_next   = CNT_W'(NUM_W);
            shift_next = dividend;
            rem_next   = '0;
        end else if (busy_reg) begin
            shift_next = shift_reg << 1;
            cnt_next   = cnt_reg - CNT_W'(1);
            if (trial >= {1'b0, divisor}) begin
                rem_next = diff[DIV_W-1:0];
            end else begin
                rem_next = trial[DIV_W-1:0];
            end
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        cnt_reg   <= cnt_next;
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign sts.done     = done_reg;
    assign sts.rem_zero = (rem_reg == '0);

endmodule
`default_nettype wire

// ----- sv/trial_division_prime_test.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// trial_division_prime_test: primality test by trial division
// divisors 2, 3, 4, ... are tried while divisor squared is at most the
// candidate; any zero remainder means not prime; 0 and 1 are not prime
// ----------------------------------------------------------------------------
//  channel   ports                          direction   word
//  input     s_valid s_ready s_candidate    in          16-bit candidate
//  result    m_valid m_ready m_prime        out         1-bit verdict
//
//  one candidate takes up to about sqrt(n) trials; each trial is one pass of
//  the bit-serial remainder unit over the candidate bits
//  s_ready is high only while the sequencer is idle; a finished verdict sits
//  in the output register so the next candidate can be taken while it waits
//  reset is synchronous and active low and clears all control state
// ----------------------------------------------------------------------------
module trial_division_prime_test
    import tdp_pkg::*;
#(
    parameter int NUMBER_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_candidate,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_prime
);

    localparam int CAND_W = (NUMBER_WIDTH < 16) ? NUMBER_WIDTH : 16;
    localparam int DW     = (CAND_W + 1) / 2 + 1;
    localparam int SQ_W   = 2 * DW;

    tdp_state_t    state_reg, state_next;
    logic [CAND_W-1:0] n_reg,  n_next;
    logic [DW-1:0]     d_reg,  d_next;
    logic [SQ_W-1:0]   sq_reg, sq_next;
    logic              res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_prime_reg, m_prime_next;

    logic              in_accept;
    logic              out_free;
    logic              n_small;
    logic              sq_over;
    logic              div_start;
    tdp_rem_sts_t      rem_sts;

    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign n_small   = (n_reg < CAND_W'(2));
    assign sq_over   = (sq_reg > SQ_W'(n_reg));

    // shared remainder unit
    tdp_rem_unit #(
        .NUM_W (CAND_W),
        .DIV_W (DW)
    ) u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (n_reg),
        .divisor  (d_reg),
        .sts      (rem_sts)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_accept) state_next = S_CHECK;
            end
            S_CHECK: begin
                if (n_small || sq_over) state_next = S_DONE;
                else                    state_next = S_DIV;
            end
            S_DIV: begin
                if (rem_sts.done) begin
                    if (rem_sts.rem_zero) state_next = S_DONE;
                    else                  state_next = S_CHECK;
                end
            end
            S_DONE: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            S_IDLE:  s_ready   = 1'b1;
            S_CHECK: div_start = !n_small && !sq_over;
            S_DIV:   ;
            S_DONE:  ;
            default: ;
        endcase
    end

    // divisor, running square and verdict
    always_comb begin
        n_next       = n_reg;
        d_next       = d_reg;
        sq_next      = sq_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_prime_next = m_prime_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (in_accept) begin
            n_next  = s_candidate[CAND_W-1:0];
            d_next  = DW'(2);
            sq_next = SQ_W'(4);
        end
        if (state_reg == S_CHECK) begin
            if (n_small)      res_next = 1'b0;
            else if (sq_over) res_next = 1'b1;
        end
        if (state_reg == S_DIV && rem_sts.done) begin
            if (rem_sts.rem_zero) begin
                res_next = 1'b0;
            end else begin
                // (d+1)^2 = d^2 + 2d + 1
                sq_next = sq_reg + SQ_W'({d_reg, 1'b1});
                d_next  = d_reg + DW'(1);
            end
        end
        if (state_reg == S_DONE && out_free) begin
            m_valid_next = 1'b1;
            m_prime_next = res_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        d_reg       <= d_next;
        sq_reg      <= sq_next;
        res_reg     <= res_next;
        m_prime_reg <= m_prime_next;
    end

    assign m_valid = m_valid_reg;
    assign m_prime = m_prime_reg;

    // a fresh word restarts the scan at divisor two
    a_start_two: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> (state_reg == S_CHECK) && (d_reg == DW'(2)))
        else $error("scan did not restart at divisor two");

    // running square tracks the divisor while a scan is active
    a_square: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHECK || state_reg == S_DIV) |->
            (sq_reg == SQ_W'({{DW{1'b0}}, d_reg} * {{DW{1'b0}}, d_reg})))
        else $error("running square out of step with divisor");

    // a prime verdict never comes for zero or one
    a_small: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && res_reg) |-> (n_reg >= CAND_W'(2)))
        else $error("zero or one reported as prime");

    // the remainder unit only reports while the sequencer waits on it
    a_rem_done: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_sts.done |-> (state_reg == S_DIV))
        else $error("remainder done outside a trial");

endmodule
`default_nettype wire
